// ===== rtl/ima_pkg.sv =====
package ima_pkg;

	localparam int INDEX_BITS_DEF = 10;
	localparam int IDX_MAX_BITS   = 16;
	localparam int NUM_SUMS       = 10;
	localparam int FIFO_DEPTH     = 4;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_USE_MASK = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_X    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Y    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Z    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_X = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Y = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Z = 3'd6;

	localparam logic [63:0] ROW_X_RESET = 64'd256;
	localparam logic [63:0] ROW_Y_RESET = 64'd16777216;
	localparam logic [63:0] ROW_Z_RESET = 64'd1099511627776;

	typedef struct packed {
		logic                    use_mask;
		logic [2:0][63:0]        row;
		logic [2:0][23:0]        centre;
	} cfg_t;

	typedef struct packed {
		logic [IDX_MAX_BITS-1:0] i;
		logic [IDX_MAX_BITS-1:0] j;
		logic [IDX_MAX_BITS-1:0] k;
		logic signed [15:0]      sample;
		logic                    counted;
		logic                    last;
	} entry_t;

	// Clamp a wide signed value to the signed 64-bit range.
	function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
		logic signed [63:0] r;
		if (v > 128'sh7fffffffffffffff)
			r = 64'sh7fffffffffffffff;
		else if (v < -128'sh8000000000000000)
			r = 64'sh8000000000000000;
		else
			r = v[63:0];
		return r;
	endfunction

	function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			r = s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
		else
			r = s[63:0];
		return r;
	endfunction

endpackage

// ===== rtl/ima_voxel_if.sv =====
interface ima_voxel_if import ima_pkg::*; #(parameter int INDEX_BITS = INDEX_BITS_DEF);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] index_i;
	logic [INDEX_BITS-1:0] index_j;
	logic [INDEX_BITS-1:0] index_k;
	logic signed [15:0]    sample;
	logic signed [15:0]    mask_sample;
	logic                  last_voxel;

	modport source (output valid, index_i, index_j, index_k, sample, mask_sample,
		last_voxel, input ready);
	modport sink (input valid, index_i, index_j, index_k, sample, mask_sample,
		last_voxel, output ready);
endinterface

// ===== rtl/ima_moment_if.sv =====
interface ima_moment_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] mass;
	logic signed [63:0] first_x;
	logic signed [63:0] first_y;
	logic signed [63:0] first_z;
	logic signed [63:0] cross_xy;
	logic signed [63:0] cross_yz;
	logic signed [63:0] cross_xz;
	logic signed [63:0] square_x;
	logic signed [63:0] square_y;
	logic signed [63:0] square_z;

	modport source (output valid, mass, first_x, first_y, first_z, cross_xy, cross_yz,
		cross_xz, square_x, square_y, square_z, input ready);
	modport sink (input valid, mass, first_x, first_y, first_z, cross_xy, cross_yz,
		cross_xz, square_x, square_y, square_z, output ready);
endinterface

// ===== rtl/ima_front.sv =====
module ima_front import ima_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	ima_voxel_if.sink vox,
	input  logic      use_mask,
	input  logic      full,
	output logic      push,
	output entry_t    push_data
);

	assign vox.ready = !full;
	assign push      = vox.valid && !full;

	always_comb begin
		push_data         = '0;
		push_data.i       = IDX_MAX_BITS'(vox.index_i);
		push_data.j       = IDX_MAX_BITS'(vox.index_j);
		push_data.k       = IDX_MAX_BITS'(vox.index_k);
		push_data.sample  = vox.sample;
		// A voxel counts when masking is off or its mask sample is positive.
		push_data.counted = !use_mask || (vox.mask_sample > 16'sd0);
		push_data.last    = vox.last_voxel;
	end

endmodule

// ===== rtl/ima_fifo.sv =====
module ima_fifo import ima_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t pop_data,
	output logic   full,
	output logic   empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t           mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             do_pop;
	logic             do_push;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_pop   = pop && !empty;
	assign do_push  = push && !full;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end

endmodule

// ===== rtl/ima_back.sv =====
module ima_back import ima_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cfg_t           cfg,
	input  logic           empty,
	input  entry_t         head,
	output logic           pop,
	ima_moment_if.source   res
);

	localparam int IW = INDEX_BITS + 17;
	localparam int CW = INDEX_BITS + 19;
	localparam int DW = ((CW > 24) ? CW : 24) + 1;
	localparam int PW = 2 * DW;
	localparam int TW = PW + 16;
	localparam int FW = CW + 16;

	logic en;
	logic out_valid_q;
	logic signed [63:0] out_q [NUM_SUMS];
	logic signed [63:0] sum_q [NUM_SUMS];

	assign en  = !out_valid_q || res.ready;
	assign pop = en && !empty;

	// Stage 1: coefficient times index products.
	logic              v_s1, cnt_s1, last_s1;
	logic signed [15:0] s_s1;
	logic signed [IW-1:0] p_s1 [3][3];
	logic signed [15:0] off_s1 [3];
	// Stage 2: coordinates and centred coordinates.
	logic              v_s2, cnt_s2, last_s2;
	logic signed [15:0] s_s2;
	logic signed [CW-1:0] x_s2 [3];
	logic signed [DW-1:0] xc_s2 [3];
	// Stage 3: first moments and coordinate pair products.
	logic              v_s3, cnt_s3, last_s3;
	logic signed [15:0] s_s3;
	logic signed [FW-1:0] f_s3 [3];
	logic signed [PW-1:0] pr_s3 [6];
	// Stage 4: pair products times sample.
	logic              v_s4, cnt_s4, last_s4;
	logic signed [15:0] s_s4;
	logic signed [FW-1:0] f_s4 [3];
	logic signed [TW-1:0] t_s4 [6];
	// Stage 5: saturated terms.
	logic              v_s5, cnt_s5, last_s5;
	logic signed [63:0] term_s5 [NUM_SUMS];

	logic [INDEX_BITS-1:0] idx [3];
	assign idx[0] = head.i[INDEX_BITS-1:0];
	assign idx[1] = head.j[INDEX_BITS-1:0];
	assign idx[2] = head.k[INDEX_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1    <= head.sample;
			cnt_s1  <= head.counted;
			last_s1 <= head.last;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					p_s1[r][c] <= IW'($signed(cfg.row[r][16*c +: 16])
						* $signed({1'b0, idx[c]}));
				off_s1[r] <= $signed(cfg.row[r][48 +: 16]);
			end

			s_s2    <= s_s1;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
			for (int r = 0; r < 3; r++) begin
				x_s2[r]  <= CW'(p_s1[r][0]) + CW'(p_s1[r][1]) + CW'(p_s1[r][2])
					+ CW'(off_s1[r]);
				xc_s2[r] <= DW'(p_s1[r][0]) + DW'(p_s1[r][1]) + DW'(p_s1[r][2])
					+ DW'(off_s1[r]) - DW'($signed(cfg.centre[r]));
			end

			s_s3    <= s_s2;
			cnt_s3  <= cnt_s2;
			last_s3 <= last_s2;
			for (int r = 0; r < 3; r++)
				f_s3[r] <= FW'(x_s2[r] * s_s2);
			pr_s3[0] <= PW'(xc_s2[0] * xc_s2[1]);
			pr_s3[1] <= PW'(xc_s2[1] * xc_s2[2]);
			pr_s3[2] <= PW'(xc_s2[0] * xc_s2[2]);
			pr_s3[3] <= PW'(xc_s2[0] * xc_s2[0]);
			pr_s3[4] <= PW'(xc_s2[1] * xc_s2[1]);
			pr_s3[5] <= PW'(xc_s2[2] * xc_s2[2]);

			s_s4    <= s_s3;
			cnt_s4  <= cnt_s3;
			last_s4 <= last_s3;
			f_s4    <= f_s3;
			for (int n = 0; n < 6; n++)
				t_s4[n] <= TW'(pr_s3[n] * s_s3);

			cnt_s5     <= cnt_s4;
			last_s5    <= last_s4;
			term_s5[0] <= 64'(s_s4);
			for (int r = 0; r < 3; r++)
				term_s5[r+1] <= 64'(f_s4[r]);
			for (int n = 0; n < 6; n++)
				term_s5[n+4] <= sat64(128'(t_s4[n]));
		end
	end

	// Accumulate; a last voxel moves the totals to the output register and clears.
	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [63:0] nv;
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int n = 0; n < NUM_SUMS; n++)
				sum_q[n] <= '0;
		end else if (en) begin
			out_valid_q <= 1'b0;
			if (v_s5) begin
				for (int n = 0; n < NUM_SUMS; n++) begin
					nv = cnt_s5 ? add_sat(sum_q[n], term_s5[n]) : sum_q[n];
					sum_q[n] <= last_s5 ? 64'sd0 : nv;
				end
				out_valid_q <= last_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5 && last_s5) begin
			for (int n = 0; n < NUM_SUMS; n++)
				out_q[n] <= cnt_s5 ? add_sat(sum_q[n], term_s5[n]) : sum_q[n];
		end
	end

	assign res.valid    = out_valid_q;
	assign res.mass     = out_q[0];
	assign res.first_x  = out_q[1];
	assign res.first_y  = out_q[2];
	assign res.first_z  = out_q[3];
	assign res.cross_xy = out_q[4];
	assign res.cross_yz = out_q[5];
	assign res.cross_xz = out_q[6];
	assign res.square_x = out_q[7];
	assign res.square_y = out_q[8];
	assign res.square_z = out_q[9];

endmodule

// ===== rtl/image_moment_accumulator.sv =====
// Channel   Direction  Transfer moves
// vox       in         one voxel: indices, sample, mask sample, last flag
// res       out        ten saturated 64-bit moment sums, once per volume
// cfg_*     in         register write: enable, index, 64-bit data
//
// One voxel per cycle is sustained while res is ready; a last voxel passes the
// queue, five back pipeline stages and one accumulate before its result shows.
// Reset sets 256 on the affine diagonal, zero centre, masking off, clears the sums.
// While a result waits at res the back pipeline holds; a four-entry queue keeps
// vox open until it fills.
module image_moment_accumulator import ima_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	ima_voxel_if.sink               vox,
	ima_moment_if.source            res,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [63:0]             cfg_data
);

	cfg_t   cfg_q;
	logic   full;
	logic   empty;
	logic   push;
	logic   pop;
	entry_t push_data;
	entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_mask <= 1'b0;
			cfg_q.row[0]   <= ROW_X_RESET;
			cfg_q.row[1]   <= ROW_Y_RESET;
			cfg_q.row[2]   <= ROW_Z_RESET;
			cfg_q.centre   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_USE_MASK: cfg_q.use_mask  <= cfg_data[0];
				REG_ROW_X:    cfg_q.row[0]    <= cfg_data;
				REG_ROW_Y:    cfg_q.row[1]    <= cfg_data;
				REG_ROW_Z:    cfg_q.row[2]    <= cfg_data;
				REG_CENTRE_X: cfg_q.centre[0] <= cfg_data[23:0];
				REG_CENTRE_Y: cfg_q.centre[1] <= cfg_data[23:0];
				REG_CENTRE_Z: cfg_q.centre[2] <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	ima_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.vox       (vox),
		.use_mask  (cfg_q.use_mask),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	ima_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.full      (full),
		.empty     (empty)
	);

	ima_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.res    (res)
	);

endmodule
